@@ rtl/core/pf_pkg.sv @@
// Shared constants and types of the prime factorizer.
package pf_pkg;

	localparam int VALUE_BITS_DEF = 31;
	localparam int MAX_RESULTS    = 31;
	localparam int CNT_BITS       = $clog2(MAX_RESULTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIVIAL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_SHIFT,
		ST_FLUSH
	} state_t;

	// Handshake between the sequencer and the divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/core/pf_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module pf_div #(
	parameter int W = pf_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          dividend,
	input  logic [W-1:0]          divisor,
	output pf_pkg::div_stat_t     stat,
	output logic [W-1:0]          quot,
	output logic [W-1:0]          rem
);
	import pf_pkg::*;

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quot_q;
	logic [W-1:0]  rem_q;

	logic [W:0]    trial;
	logic [W-1:0]  rem_next;
	logic          qbit;

	always_comb begin
		trial = {rem_q, quot_q[W-1]} - {1'b0, divisor};
		if (!trial[W]) begin
			rem_next = trial[W-1:0];
			qbit     = 1'b1;
		end else begin
			rem_next = {rem_q[W-2:0], quot_q[W-1]};
			qbit     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[W-2:0], qbit};
			rem_q  <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;
	assign rem       = rem_q;

endmodule

@@ rtl/core/prime_factorizer.sv @@
// Top level of the prime factorizer: trial-division sequencer and output register.
// Takes one unsigned value on the s_ stream and returns its prime factors in
// ascending order, with repeats, on the m_ stream; m_tlast marks the final item of
// each run. Values 0 and 1 give one item with has_factor (m_tuser) low. The block
// accepts a value only when the previous run has been fully handed to the output
// register. Every trial divisor costs one pass of the shared bit-serial divider,
// and each factor found costs one more such pass; divisors run from 2 up to the
// square root of the shrinking remainder, so a value with small factors finishes
// far sooner than a prime of the same width. Waiting on m_tready stalls the run.
module prime_factorizer #(
	parameter int VALUE_BITS = pf_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // value
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((VALUE_BITS + 7) / 8) * 8-1:0] m_tdata,  // factor
	output logic                                 m_tuser,  // has_factor
	output logic                                 m_tlast   // last
);
	import pf_pkg::*;

	localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;
	localparam int D_W    = (VALUE_BITS + 1) / 2 + 1;

	state_t              state_q, state_d;
	logic [VALUE_BITS-1:0] rem_q;
	logic [D_W-1:0]      div_q;
	logic [D_W-1:0]      pend_q;
	logic                pend_vld_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic                  out_vld_q;
	logic [VALUE_BITS-1:0] out_fac_q;
	logic                  out_has_q;
	logic                  out_last_q;

	div_stat_t             dstat;
	logic                  div_start;
	logic [VALUE_BITS-1:0] quot;
	logic [VALUE_BITS-1:0] drem;
	logic [VALUE_BITS-1:0] div_ext;
	logic [VALUE_BITS-1:0] pend_ext;
	logic [VALUE_BITS-1:0] in_val;

	logic                  out_free;
	logic                  push;
	logic [VALUE_BITS-1:0] push_fac;
	logic                  push_has;
	logic                  push_last;
	logic                  at_limit;

	assign div_ext  = {{(VALUE_BITS - D_W){1'b0}}, div_q};
	assign pend_ext = {{(VALUE_BITS - D_W){1'b0}}, pend_q};
	assign in_val   = s_tdata[VALUE_BITS-1:0];
	assign out_free = !out_vld_q || m_tready;
	assign at_limit = (cnt_q == CNT_BITS'(MAX_RESULTS - 1));

	pf_div #(
		.W(VALUE_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rem_q),
		.divisor (div_ext),
		.stat    (dstat),
		.quot    (quot),
		.rem     (drem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		push      = 1'b0;
		push_fac  = pend_ext;
		push_has  = 1'b1;
		push_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (in_val <= VALUE_BITS'(1)) ? ST_TRIVIAL : ST_DIV_START;
				end
			end
			ST_TRIVIAL: begin
				if (out_free) begin
					push      = 1'b1;
					push_fac  = '0;
					push_has  = 1'b0;
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (dstat.done) begin
					if (div_ext > quot) begin
						state_d = ST_FLUSH;
					end else if (drem == '0 && pend_vld_q) begin
						state_d = ST_SHIFT;
					end else begin
						state_d = ST_DIV_START;
					end
				end
			end
			ST_SHIFT: begin
				// Hand the older factor on; the new one stays pending.
				if (out_free) begin
					push      = 1'b1;
					push_last = at_limit;
					state_d   = at_limit ? ST_IDLE : ST_DIV_START;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push = 1'b1;
					if (pend_vld_q) begin
						push_last = (rem_q == VALUE_BITS'(1)) || at_limit;
						state_d   = push_last ? ST_IDLE : ST_FLUSH;
					end else begin
						push_fac  = rem_q;
						push_last = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (state_q == ST_IDLE && s_tvalid) begin
				pend_vld_q <= 1'b0;
				cnt_q      <= '0;
			end else begin
				if (push && push_has && !push_last) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (state_q == ST_DIV_WAIT && dstat.done && div_ext <= quot && drem == '0) begin
					pend_vld_q <= 1'b1;
				end else if (state_q == ST_FLUSH && out_free) begin
					pend_vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			rem_q <= in_val;
			div_q <= D_W'(2);
		end else if (state_q == ST_DIV_WAIT && dstat.done && div_ext <= quot) begin
			if (drem == '0) begin
				// Divide out the factor; retry the same divisor.
				rem_q <= quot;
				if (!pend_vld_q) begin
					pend_q <= div_q;
				end
			end else begin
				div_q <= div_q + 1'b1;
			end
		end else if (state_q == ST_SHIFT && out_free) begin
			pend_q <= div_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_fac_q  <= push_fac;
			out_has_q  <= push_has;
			out_last_q <= push_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(DATA_W - VALUE_BITS){1'b0}}, out_fac_q};
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_nofac_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("item without factor not marked last");

	a_fac_ge2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[VALUE_BITS-1:0] > VALUE_BITS'(1))
		else $error("emitted factor below two");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> state_q == ST_DIV_WAIT)
		else $error("divider finished outside wait state");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !dstat.busy)
		else $error("divider restarted while busy");
`endif

endmodule
